// ===== sv/lap_pkg.sv =====
// ----------------------------------------------------------------------------
// lap_pkg
// Shared opcodes, result kinds, field widths and the result record of the
// line allocation map.
// ----------------------------------------------------------------------------
package lap_pkg;

    localparam int OPCODE_W = 2;
    localparam int START_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int OWNER_W  = 16;
    localparam int KIND_W   = 3;

    localparam logic [OPCODE_W-1:0] OP_SCAN    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FREE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] extent_start;
        logic [COUNT_W-1:0] extent_length;
        logic               last;
    } lap_result_t;

endpackage

// ===== sv/lap_in_if.sv =====
// ----------------------------------------------------------------------------
// lap_in_if
// Request channel: one command item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface lap_in_if import lap_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [START_W-1:0]  start_line;
    logic [COUNT_W-1:0]  line_count;
    logic [OWNER_W-1:0]  owner_id;

    modport source (output valid, output opcode, output start_line,
                    output line_count, output owner_id, input ready);
    modport sink   (input valid, input opcode, input start_line,
                    input line_count, input owner_id, output ready);

endinterface

// ===== sv/lap_out_if.sv =====
// ----------------------------------------------------------------------------
// lap_out_if
// Response channel: one result item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface lap_out_if import lap_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] extent_start;
    logic [COUNT_W-1:0] extent_length;
    logic               last;

    modport source (output valid, output kind, output extent_start,
                    output extent_length, output last, input ready);
    modport sink   (input valid, input kind, input extent_start,
                    input extent_length, input last, output ready);

endinterface

// ===== sv/lap_ram.sv =====
// ----------------------------------------------------------------------------
// lap_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. A read of the address being written returns old data.
// ----------------------------------------------------------------------------
module lap_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lap_out_stage.sv =====
// ----------------------------------------------------------------------------
// lap_out_stage
// Output register of the response channel. It takes a new result whenever
// it is empty or its current item leaves in the same cycle.
// ----------------------------------------------------------------------------
module lap_out_stage import lap_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  lap_result_t   result,
    output logic          can_load,
    lap_out_if.source     rsp
);

    logic        valid_reg;
    lap_result_t result_reg;

    assign can_load = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.kind          = result_reg.kind;
    assign rsp.extent_start  = result_reg.extent_start;
    assign rsp.extent_length = result_reg.extent_length;
    assign rsp.last          = result_reg.last;

endmodule

// ===== sv/line_allocation_map.sv =====
// One item is in work at a time and the next can be taken in the cycle after its
// final result is loaded into the output register, so throughput is set by the walk
// over the line memory, one line per cycle (through its single read port for a scan
// or release, its write port for an allocation) while the output does not stall.
// After reset a clearing pass frees every line; no item is taken until it ends.
// ----------------------------------------------------------------------------
// line_allocation_map
// Map of memory lines with a free bit and owner per line, held in one RAM.
// Handles scan of free extents, range allocation and owner release.
// ----------------------------------------------------------------------------
module line_allocation_map import lap_pkg::*; #(
    parameter int LINES      = 64,
    parameter int OWNER_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lap_in_if.sink    req,
    lap_out_if.source rsp
);

    localparam int AW = $clog2(LINES);
    localparam int CW = $clog2(LINES + 1);
    localparam int DW = OWNER_BITS + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PRIME,
        S_SCAN,
        S_SCAN_END,
        S_REL,
        S_ALLOC,
        S_RESULT
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         idx_reg;
    logic                  is_scan_reg;
    logic [AW-1:0]         run_start_reg;
    logic [CW-1:0]         run_len_reg;
    logic                  found_reg;
    logic [OWNER_BITS-1:0] own_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [KIND_W-1:0]     res_kind_reg;
    logic [START_W-1:0]    res_start_reg;
    logic [COUNT_W-1:0]    res_len_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DW-1:0]         ram_rdata;

    logic                  cur_free;
    logic [OWNER_BITS-1:0] cur_owner;
    logic                  last_line;
    logic                  held;
    logic                  scan_emit;
    logic                  stall;
    logic                  out_load;
    logic                  out_can_load;
    lap_result_t           out_result;
    logic                  range_error;
    logic [AW-1:0]         rel_start_next;
    logic [CW-1:0]         rel_len_next;
    logic                  rel_exit;

    assign cur_free  = ram_rdata[OWNER_BITS];
    assign cur_owner = ram_rdata[OWNER_BITS-1:0];
    assign last_line = (idx_reg == AW'(LINES - 1));
    assign held      = !cur_free && (cur_owner == own_reg);

    // A non-free line closes the current run; the scan waits until it is reported.
    assign scan_emit = (state_reg == S_SCAN) && !cur_free && (run_len_reg != '0);
    assign stall     = scan_emit && !out_can_load;

    assign range_error = (32'(req.start_line) + 32'(req.line_count)) > 32'(LINES);

    assign rel_start_next = (held && !found_reg) ? idx_reg : run_start_reg;
    assign rel_len_next   = run_len_reg + CW'(held);
    assign rel_exit       = (!held && found_reg) || last_line;

    assign req.ready = (state_reg == S_IDLE);

    // The read address runs one line ahead of the data being evaluated; on a
    // stall it repeats the current line so its data stays on the RAM output.
    always_comb
    begin
        ram_raddr = '0;
        if (state_reg == S_SCAN || state_reg == S_REL)
        begin
            if (stall)
            begin
                ram_raddr = idx_reg;
            end
            else if (!last_line)
            begin
                ram_raddr = idx_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {1'b1, {OWNER_BITS{1'b0}}};
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_ALLOC:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, own_reg};
            end
            S_REL:
            begin
                ram_we = held;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_load   = 1'b0;
        out_result = '{kind: KIND_FREE, extent_start: START_W'(run_start_reg),
                       extent_length: COUNT_W'(run_len_reg), last: 1'b0};
        case (state_reg)
            S_SCAN:
            begin
                out_load = scan_emit && out_can_load;
            end
            S_SCAN_END:
            begin
                out_load = out_can_load;
                if (run_len_reg == '0)
                begin
                    out_result = '{kind: KIND_END, extent_start: '0,
                                   extent_length: '0, last: 1'b1};
                end
            end
            S_RESULT:
            begin
                out_load   = out_can_load;
                out_result = '{kind: res_kind_reg, extent_start: res_start_reg,
                               extent_length: res_len_reg, last: 1'b1};
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            is_scan_reg   <= 1'b0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            found_reg     <= 1'b0;
            own_reg       <= '0;
            cnt_reg       <= '0;
            res_kind_reg  <= KIND_ERROR;
            res_start_reg <= '0;
            res_len_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (last_line)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        run_len_reg   <= '0;
                        run_start_reg <= '0;
                        found_reg     <= 1'b0;
                        own_reg       <= OWNER_BITS'(req.owner_id);
                        res_kind_reg  <= KIND_ERROR;
                        res_start_reg <= '0;
                        res_len_reg   <= '0;
                        case (req.opcode)
                            OP_SCAN:
                            begin
                                is_scan_reg <= 1'b1;
                                state_reg   <= S_PRIME;
                            end
                            OP_RELEASE:
                            begin
                                is_scan_reg <= 1'b0;
                                state_reg   <= S_PRIME;
                            end
                            OP_ALLOC:
                            begin
                                state_reg <= S_RESULT;
                                if (!range_error)
                                begin
                                    res_kind_reg  <= KIND_ALLOC;
                                    res_start_reg <= req.start_line;
                                    res_len_reg   <= req.line_count;
                                    idx_reg       <= AW'(req.start_line);
                                    cnt_reg       <= req.line_count;
                                    if (req.line_count != '0)
                                    begin
                                        state_reg <= S_ALLOC;
                                    end
                                end
                            end
                            default:
                            begin
                                state_reg <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_PRIME:
                begin
                    idx_reg   <= '0;
                    state_reg <= is_scan_reg ? S_SCAN : S_REL;
                end
                S_SCAN:
                begin
                    if (!stall)
                    begin
                        if (cur_free)
                        begin
                            if (run_len_reg == '0)
                            begin
                                run_start_reg <= idx_reg;
                            end
                            run_len_reg <= run_len_reg + CW'(1);
                        end
                        else
                        begin
                            run_len_reg <= '0;
                        end
                        if (last_line)
                        begin
                            state_reg <= S_SCAN_END;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + AW'(1);
                        end
                    end
                end
                S_SCAN_END:
                begin
                    // A run that reaches the top line goes out before the end marker.
                    if (out_can_load)
                    begin
                        if (run_len_reg != '0)
                        begin
                            run_len_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_REL:
                begin
                    found_reg     <= found_reg || held;
                    run_start_reg <= rel_start_next;
                    run_len_reg   <= rel_len_next;
                    idx_reg       <= idx_reg + AW'(1);
                    if (rel_exit)
                    begin
                        res_kind_reg  <= KIND_RELEASED;
                        res_start_reg <= START_W'(rel_start_next);
                        res_len_reg   <= COUNT_W'(rel_len_next);
                        state_reg     <= S_RESULT;
                    end
                end
                S_ALLOC:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    cnt_reg <= cnt_reg - COUNT_W'(1);
                    if (cnt_reg == COUNT_W'(1))
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (out_can_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    lap_ram #(
        .WIDTH (DW),
        .DEPTH (LINES)
    ) u_lap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lap_out_stage u_lap_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .result   (out_result),
        .can_load (out_can_load),
        .rsp      (rsp)
    );

endmodule

// ===== sv/lap_checker.sv =====
// ----------------------------------------------------------------------------
// lap_checker
// Port-level checks of the line allocation map, bound to the top level.
// ----------------------------------------------------------------------------
module lap_checker import lap_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [KIND_W-1:0]  rsp_kind,
    input logic [START_W-1:0] rsp_extent_start,
    input logic [COUNT_W-1:0] rsp_extent_length,
    input logic               rsp_last
);

    // A stalled result item holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable(rsp_kind) && $stable(rsp_extent_start)
            && $stable(rsp_extent_length) && $stable(rsp_last))
        else $error("lap: stalled result changed");

    // Only one item is in work: the block stops taking items after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("lap: request taken while another is in work");

    // Only free extents of a scan can be followed by further results.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> rsp_kind == KIND_FREE)
        else $error("lap: non-final result of wrong kind");

    // The end marker is final and carries no extent.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_END |->
            rsp_last && rsp_extent_start == '0 && rsp_extent_length == '0)
        else $error("lap: malformed end marker");

    // A free extent is never empty and never final.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_FREE |-> rsp_extent_length != '0 && !rsp_last)
        else $error("lap: empty or final free extent");

endmodule

bind line_allocation_map lap_checker u_lap_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_kind          (rsp.kind),
    .rsp_extent_start  (rsp.extent_start),
    .rsp_extent_length (rsp.extent_length),
    .rsp_last          (rsp.last)
);
